@@ rtl/ppb_pkg.sv @@
// Shared types and constants for the phosphor persistence blend.
// No dependencies; imported by ppb_decay and phosphor_persistence_blend.

package ppb_pkg;

   localparam int INDEX_W     = 18;
   localparam int CODE_W      = 8;
   localparam int MODE_W      = 3;
   localparam int PERSIST_W   = 9;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;
   localparam int PRODUCT_W   = 2 * CODE_W;

   localparam int FRAME_WIDTH_DEFAULT  = 512;
   localparam int FRAME_HEIGHT_DEFAULT = 512;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY_MODE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PERSISTENCE_Q8 = 2'd1;

   // display modes
   localparam logic [MODE_W-1:0] MODE_GREEN  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ORANGE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_LCD    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_COLOR  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FLAT   = 3'd4;

   localparam logic [CODE_W-1:0]    INDEXED_MIN  = 8'd240;
   localparam logic [CODE_W-1:0]    CODE_MAX     = 8'd255;
   localparam logic [CODE_W-1:0]    BASE_LCD     = 8'd214;
   localparam logic [CODE_W-1:0]    BASE_CRT     = 8'd224;
   localparam logic [PERSIST_W-1:0] PERSIST_MIN  = 9'd51;
   localparam logic [PERSIST_W-1:0] PERSIST_MAX  = 9'd294;
   localparam logic [PERSIST_W-1:0] PERSIST_RST  = 9'd200;

   typedef struct packed {
      logic [MODE_W-1:0]    mode;
      logic [PERSIST_W-1:0] persist;
   } cfg_type;

endpackage

@@ rtl/ppb_decay.sv @@
// Decay factor unit: clamps persistence, scales the mode base, saturates.
// Depends on ppb_pkg. Output is registered.

module ppb_decay
   import ppb_pkg::*;
(
   input  logic              clock,
   input  cfg_type           cfg,
   output logic [CODE_W-1:0] decay
);

   logic [PERSIST_W-1:0]        p_clamped;
   logic [CODE_W-1:0]           base;
   logic [CODE_W+PERSIST_W-1:0] scaled;
   logic [PERSIST_W-1:0]        shifted;
   logic [CODE_W-1:0]           decay_in;
   logic [CODE_W-1:0]           decay_ff;

   always_comb begin
      if (cfg.persist < PERSIST_MIN) begin
         p_clamped = PERSIST_MIN;
      end else if (cfg.persist > PERSIST_MAX) begin
         p_clamped = PERSIST_MAX;
      end else begin
         p_clamped = cfg.persist;
      end
      base    = (cfg.mode == MODE_LCD) ? BASE_LCD : BASE_CRT;
      scaled  = (CODE_W+PERSIST_W)'(base) * (CODE_W+PERSIST_W)'(p_clamped);
      shifted = scaled[CODE_W+PERSIST_W-1:CODE_W];
      // saturate to a byte
      decay_in = (shifted > PERSIST_W'(CODE_MAX)) ? CODE_MAX : shifted[CODE_W-1:0];
   end

   always_ff @(posedge clock) begin
      decay_ff <= decay_in;
   end

   assign decay = decay_ff;

endmodule

@@ rtl/phosphor_persistence_blend.sv @@
// Top level of the phosphor persistence blend: afterglow store, pipeline, CSRs.
// Depends on ppb_pkg and ppb_decay.
//
// Usage
//   req_ channel: one transaction carries a pixel position and its new code.
//   rsp_ channel: one transaction per request, in order, with the shown code.
//   csr_ port: write display_mode (index 0) or persistence_q8 (index 1) while
//   the block is idle; other indexes are ignored.
// Timing
//   Three register stages: store read, decay multiply with write-back, output
//   register. rsp_valid rises once an accepted request has passed all three.
//   One transaction per cycle is sustained while rsp_ready allows, including
//   repeated hits on one position, served from bypass paths around the store.
// Reset
//   After reset the store is cleared one entry per cycle, all FRAME_WIDTH *
//   FRAME_HEIGHT entries (capped at 262144), with req_ready low throughout.
// Stall
//   While rsp_valid is high and rsp_ready low the whole pipeline holds and
//   req_ready drops; nothing is lost or repeated.

module phosphor_persistence_blend
   import ppb_pkg::*;
#(
   parameter int FRAME_WIDTH  = FRAME_WIDTH_DEFAULT,
   parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEFAULT
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [INDEX_W-1:0]     req_pixel_index,
   input  logic [CODE_W-1:0]      req_pixel_code,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CODE_W-1:0]      rsp_shown_code,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int STORE_DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int MEM_DEPTH   = (STORE_DEPTH > (1 << INDEX_W)) ? (1 << INDEX_W) : STORE_DEPTH;
   localparam int AW          = $clog2(MEM_DEPTH);
   localparam logic [AW-1:0] CLR_LAST = AW'(MEM_DEPTH - 1);

   // configuration
   cfg_type           cfg_ff, cfg_in;
   logic [CODE_W-1:0] decay;
   logic              bypass;

   // store and clearing pass
   logic [CODE_W-1:0] store [MEM_DEPTH];
   logic              clr_busy_ff, clr_busy_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;

   // pipeline
   logic              advance;
   logic              accept;
   logic              req_inside;

   logic              s1_valid_ff, s1_inside_ff;
   logic [AW-1:0]     s1_addr_ff;
   logic [CODE_W-1:0] s1_code_ff, s1_rd_ff;
   logic [CODE_W-1:0] s1_prev, s1_mono;
   logic [PRODUCT_W-1:0] s1_product;

   logic              s2_valid_ff, s2_inside_ff;
   logic [AW-1:0]     s2_addr_ff;
   logic [CODE_W-1:0] s2_code_ff;
   logic [PRODUCT_W-1:0] s2_product_ff;
   logic [CODE_W-1:0] s2_decayed, s2_shown;

   logic              wb_valid_ff;
   logic [AW-1:0]     wb_addr_ff;
   logic [CODE_W-1:0] wb_data_ff;

   logic              out_valid_ff;
   logic [CODE_W-1:0] out_code_ff;

   // ---------------------------------------------------------------- CSRs
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_DISPLAY_MODE:   cfg_in.mode    = csr_wdata[MODE_W-1:0];
            CSR_PERSISTENCE_Q8: cfg_in.persist = csr_wdata[PERSIST_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode    <= MODE_GREEN;
         cfg_ff.persist <= PERSIST_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ppb_decay u_decay (
      .clock (clock),
      .cfg   (cfg_ff),
      .decay (decay)
   );

   assign bypass = cfg_ff.mode inside {MODE_COLOR, MODE_FLAT};

   // ---------------------------------------------------------------- control
   assign advance    = !out_valid_ff || rsp_ready;
   assign req_ready  = advance && !clr_busy_ff;
   assign accept     = req_valid && req_ready;
   assign req_inside = 32'(req_pixel_index) < STORE_DEPTH;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == CLR_LAST) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- stage 1
   // newest pending write wins: stage 2 result, then last written entry
   always_comb begin
      if (!s1_inside_ff) begin
         s1_prev = '0;
      end else if (s2_valid_ff && s2_inside_ff && (s2_addr_ff == s1_addr_ff)) begin
         s1_prev = s2_shown;
      end else if (wb_valid_ff && (wb_addr_ff == s1_addr_ff)) begin
         s1_prev = wb_data_ff;
      end else begin
         s1_prev = s1_rd_ff;
      end
      // indexed colours do not glow
      s1_mono    = (s1_prev >= INDEXED_MIN) ? '0 : s1_prev;
      s1_product = PRODUCT_W'(s1_mono) * PRODUCT_W'(decay);
   end

   // ---------------------------------------------------------------- stage 2
   always_comb begin
      s2_decayed = s2_product_ff[PRODUCT_W-1:CODE_W];
      if (bypass || (s2_code_ff >= INDEXED_MIN)) begin
         s2_shown = s2_code_ff;
      end else begin
         s2_shown = (s2_code_ff > s2_decayed) ? s2_code_ff : s2_decayed;
      end
   end

   // ---------------------------------------------------------------- store
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         store[clr_addr_ff] <= '0;
      end else if (advance && s2_valid_ff && s2_inside_ff) begin
         store[s2_addr_ff] <= s2_shown;
      end
      if (accept && req_inside) begin
         s1_rd_ff <= store[req_pixel_index[AW-1:0]];
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         wb_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
         if (advance) begin
            s1_valid_ff  <= accept;
            s2_valid_ff  <= s1_valid_ff;
            wb_valid_ff  <= s2_valid_ff && s2_inside_ff;
            out_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_inside_ff  <= req_inside;
         s1_addr_ff    <= req_pixel_index[AW-1:0];
         s1_code_ff    <= req_pixel_code;
         s2_inside_ff  <= s1_inside_ff;
         s2_addr_ff    <= s1_addr_ff;
         s2_code_ff    <= s1_code_ff;
         s2_product_ff <= s1_product;
         wb_addr_ff    <= s2_addr_ff;
         wb_data_ff    <= s2_shown;
         out_code_ff   <= s2_shown;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_shown_code = out_code_ff;

   // ---------------------------------------------------------------- checks
   a_no_item_during_clear : assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !s1_valid_ff && !s2_valid_ff && !out_valid_ff)
      else $error("pipeline holds a transaction during store clear");

   a_clear_runs_once : assert property (@(posedge clock) disable iff (reset)
      !clr_busy_ff |=> !clr_busy_ff)
      else $error("store clear restarted without reset");

   a_stall_holds_pipe : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(s1_valid_ff) && $stable(s2_valid_ff) && $stable(wb_valid_ff))
      else $error("pipeline moved while stalled");

   a_wb_follows_s2 : assert property (@(posedge clock) disable iff (reset)
      advance && s2_valid_ff && s2_inside_ff |=> wb_valid_ff && out_valid_ff)
      else $error("write-back bypass lost a store update");

endmodule
